FILE: hdl/c80alu_pkg.sv
// c80alu_pkg: operation codes, payload structs and pipeline stage types
// for the 8080 alu block; no dependencies
`timescale 1ns / 1ps

package c80alu_pkg;

  // operation codes carried in the kind field
  localparam logic [3:0] KIND_ADD = 4'd0;
  localparam logic [3:0] KIND_ADC = 4'd1;
  localparam logic [3:0] KIND_SUB = 4'd2;
  localparam logic [3:0] KIND_SBB = 4'd3;
  localparam logic [3:0] KIND_ANA = 4'd4;
  localparam logic [3:0] KIND_XRA = 4'd5;
  localparam logic [3:0] KIND_ORA = 4'd6;
  localparam logic [3:0] KIND_CMP = 4'd7;
  localparam logic [3:0] KIND_INR = 4'd8;
  localparam logic [3:0] KIND_DCR = 4'd9;
  localparam logic [3:0] KIND_RRC = 4'd10;
  localparam logic [3:0] KIND_DAD = 4'd11;

  // flag byte bit positions (psw layout)
  localparam int unsigned FLG_S_BIT  = 7;
  localparam int unsigned FLG_Z_BIT  = 6;
  localparam int unsigned FLG_AC_BIT = 4;
  localparam int unsigned FLG_P_BIT  = 2;
  localparam int unsigned FLG_CY_BIT = 0;

  // input transfer
  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] first_operand;
    logic [15:0] second_operand;
    logic [7:0]  flags_in;
  } alu_in_t;

  // result transfer
  typedef struct packed {
    logic [15:0] result;
    logic [7:0]  flags_out;
  } alu_out_t;

  // first stage: adder operands prepared per operation
  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] op_a;
    logic [15:0] op_b;
    logic        carry_in;
    logic [7:0]  flags_in;
  } prep_t;

  // second stage: value, carry and half carry settled
  typedef struct packed {
    logic [15:0] result;
    logic [7:0]  szp_byte;
    logic        szp_upd;
    logic        ac_upd;
    logic        ac;
    logic        cy;
    logic [7:0]  flags_in;
  } exec_t;

endpackage

FILE: hdl/cpu8080_alu_flags_top.sv
// 8080 arithmetic-logic unit with psw flag logic, three register stages
// depends on c80alu_pkg
// done is registered behind prep_vld and exec_vld after the accepting edge (start high, busy low)
// throughput: one transfer per cycle, back to back; busy is high only in reset
// stages: operand prep, 17-bit adder with nibble carry, flag assembly
// reset clears the stage valid bits and done; payload registers hold no reset
// results cannot be stalled: each shows for exactly one cycle under done
`timescale 1ns / 1ps

module cpu8080_alu_flags_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  c80alu_pkg::alu_in_t  req,
  output logic                 done,
  output c80alu_pkg::alu_out_t rsp
);

  logic               accept;
  c80alu_pkg::prep_t  prep_next;
  c80alu_pkg::prep_t  prep;
  logic               prep_vld;
  c80alu_pkg::exec_t  exec_next;
  c80alu_pkg::exec_t  exec;
  logic               exec_vld;
  c80alu_pkg::alu_out_t rsp_next;

  logic [16:0] sum;
  logic [4:0]  half;
  logic        cin;
  logic [7:0]  fk;

  assign busy   = rst;
  assign accept = start & ~busy;

  // stage 1: pick adder operands and carry in
  always_comb begin
    cin                 = req.flags_in[c80alu_pkg::FLG_CY_BIT];
    prep_next.kind      = req.kind;
    prep_next.flags_in  = req.flags_in;
    prep_next.op_a      = {8'h00, req.first_operand[7:0]};
    prep_next.op_b      = {8'h00, req.second_operand[7:0]};
    prep_next.carry_in  = 1'b0;
    case (req.kind)
      c80alu_pkg::KIND_ADC: begin
        prep_next.carry_in = cin;
      end
      c80alu_pkg::KIND_SUB, c80alu_pkg::KIND_CMP: begin
        prep_next.op_b     = {8'h00, ~req.second_operand[7:0]};
        prep_next.carry_in = 1'b1;
      end
      c80alu_pkg::KIND_SBB: begin
        prep_next.op_b     = {8'h00, ~req.second_operand[7:0]};
        prep_next.carry_in = ~cin;
      end
      c80alu_pkg::KIND_INR: begin
        prep_next.op_b     = 16'h0000;
        prep_next.carry_in = 1'b1;
      end
      c80alu_pkg::KIND_DCR: begin
        prep_next.op_b     = 16'h00FF;
      end
      c80alu_pkg::KIND_DAD: begin
        prep_next.op_a     = req.first_operand;
        prep_next.op_b     = req.second_operand;
      end
      default: begin
        // unused codes return the whole first operand
        if (req.kind > c80alu_pkg::KIND_DAD) begin
          prep_next.op_a = req.first_operand;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_vld <= 1'b0;
    end else begin
      prep_vld <= accept;
    end
    prep <= prep_next;
  end

  // stage 2: shared adder and per-operation result
  always_comb begin
    sum  = {1'b0, prep.op_a} + {1'b0, prep.op_b} + {16'h0000, prep.carry_in};
    half = {1'b0, prep.op_a[3:0]} + {1'b0, prep.op_b[3:0]} + {4'h0, prep.carry_in};
    exec_next.flags_in = prep.flags_in;
    exec_next.result   = {8'h00, sum[7:0]};
    exec_next.szp_byte = sum[7:0];
    exec_next.szp_upd  = 1'b1;
    exec_next.ac_upd   = 1'b1;
    exec_next.ac       = half[4];
    exec_next.cy       = sum[8];
    case (prep.kind)
      c80alu_pkg::KIND_ADD, c80alu_pkg::KIND_ADC: begin
        exec_next.cy = sum[8];
      end
      c80alu_pkg::KIND_SUB, c80alu_pkg::KIND_SBB: begin
        exec_next.cy = ~sum[8];
      end
      c80alu_pkg::KIND_CMP: begin
        exec_next.cy     = ~sum[8];
        exec_next.result = prep.op_a;
      end
      c80alu_pkg::KIND_ANA: begin
        exec_next.result   = prep.op_a & prep.op_b;
        exec_next.szp_byte = prep.op_a[7:0] & prep.op_b[7:0];
        exec_next.ac       = prep.op_a[3] | prep.op_b[3];
        exec_next.cy       = 1'b0;
      end
      c80alu_pkg::KIND_XRA: begin
        exec_next.result   = prep.op_a ^ prep.op_b;
        exec_next.szp_byte = prep.op_a[7:0] ^ prep.op_b[7:0];
        exec_next.ac       = 1'b0;
        exec_next.cy       = 1'b0;
      end
      c80alu_pkg::KIND_ORA: begin
        exec_next.result   = prep.op_a | prep.op_b;
        exec_next.szp_byte = prep.op_a[7:0] | prep.op_b[7:0];
        exec_next.ac       = 1'b0;
        exec_next.cy       = 1'b0;
      end
      c80alu_pkg::KIND_INR, c80alu_pkg::KIND_DCR: begin
        exec_next.cy = prep.flags_in[c80alu_pkg::FLG_CY_BIT];
      end
      c80alu_pkg::KIND_RRC: begin
        exec_next.result  = {8'h00, prep.op_a[0], prep.op_a[7:1]};
        exec_next.szp_upd = 1'b0;
        exec_next.ac_upd  = 1'b0;
        exec_next.cy      = prep.op_a[0];
      end
      c80alu_pkg::KIND_DAD: begin
        exec_next.result  = sum[15:0];
        exec_next.szp_upd = 1'b0;
        exec_next.ac_upd  = 1'b0;
        exec_next.cy      = sum[16];
      end
      default: begin
        // unused codes: pass operand and all flags through
        exec_next.result  = prep.op_a;
        exec_next.szp_upd = 1'b0;
        exec_next.ac_upd  = 1'b0;
        exec_next.cy      = prep.flags_in[c80alu_pkg::FLG_CY_BIT];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exec_vld <= 1'b0;
    end else begin
      exec_vld <= prep_vld;
    end
    exec <= exec_next;
  end

  // stage 3: sign, zero, parity and flag byte assembly
  always_comb begin
    fk = exec.flags_in;
    rsp_next.result = exec.result;
    rsp_next.flags_out[7] = exec.szp_upd ? exec.szp_byte[7]
                                         : fk[c80alu_pkg::FLG_S_BIT];
    rsp_next.flags_out[6] = exec.szp_upd ? (exec.szp_byte == 8'h00)
                                         : fk[c80alu_pkg::FLG_Z_BIT];
    rsp_next.flags_out[5] = 1'b0;
    rsp_next.flags_out[4] = exec.ac_upd ? exec.ac : fk[c80alu_pkg::FLG_AC_BIT];
    rsp_next.flags_out[3] = 1'b0;
    rsp_next.flags_out[2] = exec.szp_upd ? ~(^exec.szp_byte)
                                         : fk[c80alu_pkg::FLG_P_BIT];
    rsp_next.flags_out[1] = 1'b1;
    rsp_next.flags_out[0] = exec.cy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= exec_vld;
    end
    rsp <= rsp_next;
  end

endmodule

FILE: test/cpu8080_alu_flags_top_tb.sv
// cpu8080_alu_flags_top_tb: self-checking bench for the 8080 alu block, directed
// table then random operations, checked against typed values or a local flag model
// depends on c80alu_pkg and cpu8080_alu_flags_top
`timescale 1ns / 1ps

module cpu8080_alu_flags_top_tb;

  // spare operation codes, passed through by the block
  localparam logic [3:0] KIND_RSV12 = 4'd12;
  localparam logic [3:0] KIND_RSV13 = 4'd13;
  localparam logic [3:0] KIND_RSV14 = 4'd14;
  localparam logic [3:0] KIND_RSV15 = 4'd15;

  // psw bits that can ever be set, and the bit that always reads one
  localparam logic [7:0] FLAG_KEEP_MASK = 8'hD5;
  localparam logic [7:0] FLAG_ONE_BIT   = 8'h02;

  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    c80alu_pkg::alu_in_t  op;
    logic                 known;
    c80alu_pkg::alu_out_t want;
  } table_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  c80alu_pkg::alu_in_t  req;
  logic                 done;
  c80alu_pkg::alu_out_t rsp;

  c80alu_pkg::alu_out_t pending_alu_results[$];
  table_row_t           directed_table[$];
  c80alu_pkg::alu_out_t oldest_want;
  int                   mismatch_count = 0;

  cpu8080_alu_flags_top i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  always #10 clk = ~clk;

  // sign, zero and parity of a byte result
  function automatic logic [7:0] szp_of_byte(input logic [7:0] v);
    logic [7:0] f;
    f = 8'h00;
    f[c80alu_pkg::FLG_S_BIT] = v[7];
    f[c80alu_pkg::FLG_Z_BIT] = (v == 8'h00);
    f[c80alu_pkg::FLG_P_BIT] = ~^v;
    return f;
  endfunction

  // value and new psw for one operation
  function automatic c80alu_pkg::alu_out_t alu_predict(input c80alu_pkg::alu_in_t op);
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  nb;
    logic [7:0]  r8;
    logic [7:0]  f;
    logic [8:0]  sum9;
    logic [4:0]  half;
    logic [16:0] sum17;
    logic        cin;
    logic        c;
    logic [15:0] r;
    c80alu_pkg::alu_out_t o;
    a   = op.first_operand[7:0];
    b   = op.second_operand[7:0];
    cin = op.flags_in[c80alu_pkg::FLG_CY_BIT];
    r   = op.first_operand;
    f   = op.flags_in & FLAG_KEEP_MASK;
    case (op.kind)
      c80alu_pkg::KIND_ADD, c80alu_pkg::KIND_ADC: begin
        c    = (op.kind == c80alu_pkg::KIND_ADC) ? cin : 1'b0;
        sum9 = {1'b0, a} + {1'b0, b} + {8'h00, c};
        half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, c};
        r    = {8'h00, sum9[7:0]};
        f    = szp_of_byte(sum9[7:0]);
        f[c80alu_pkg::FLG_CY_BIT] = sum9[8];
        f[c80alu_pkg::FLG_AC_BIT] = half[4];
      end
      // subtract as add of the complement; carry out inverted gives the borrow
      c80alu_pkg::KIND_SUB, c80alu_pkg::KIND_SBB, c80alu_pkg::KIND_CMP: begin
        c    = (op.kind == c80alu_pkg::KIND_SBB) ? ~cin : 1'b1;
        nb   = ~b;
        sum9 = {1'b0, a} + {1'b0, nb} + {8'h00, c};
        half = {1'b0, a[3:0]} + {1'b0, nb[3:0]} + {4'h0, c};
        f    = szp_of_byte(sum9[7:0]);
        f[c80alu_pkg::FLG_CY_BIT] = ~sum9[8];
        f[c80alu_pkg::FLG_AC_BIT] = half[4];
        r    = (op.kind == c80alu_pkg::KIND_CMP) ? {8'h00, a} : {8'h00, sum9[7:0]};
      end
      c80alu_pkg::KIND_ANA: begin
        r8 = a & b;
        r  = {8'h00, r8};
        f  = szp_of_byte(r8);
        f[c80alu_pkg::FLG_AC_BIT] = a[3] | b[3];
      end
      c80alu_pkg::KIND_XRA: begin
        r8 = a ^ b;
        r  = {8'h00, r8};
        f  = szp_of_byte(r8);
      end
      c80alu_pkg::KIND_ORA: begin
        r8 = a | b;
        r  = {8'h00, r8};
        f  = szp_of_byte(r8);
      end
      // inc and dec keep the carry
      c80alu_pkg::KIND_INR: begin
        r8 = a + 8'd1;
        r  = {8'h00, r8};
        f  = szp_of_byte(r8);
        f[c80alu_pkg::FLG_CY_BIT] = cin;
        f[c80alu_pkg::FLG_AC_BIT] = (a[3:0] == 4'hF);
      end
      c80alu_pkg::KIND_DCR: begin
        r8 = a - 8'd1;
        r  = {8'h00, r8};
        f  = szp_of_byte(r8);
        f[c80alu_pkg::FLG_CY_BIT] = cin;
        f[c80alu_pkg::FLG_AC_BIT] = (a[3:0] != 4'h0);
      end
      c80alu_pkg::KIND_RRC: begin
        r = {8'h00, a[0], a[7:1]};
        f[c80alu_pkg::FLG_CY_BIT] = a[0];
      end
      c80alu_pkg::KIND_DAD: begin
        sum17 = {1'b0, op.first_operand} + {1'b0, op.second_operand};
        r     = sum17[15:0];
        f[c80alu_pkg::FLG_CY_BIT] = sum17[16];
      end
      default: begin
      end
    endcase
    o.result    = r;
    o.flags_out = (f & FLAG_KEEP_MASK) | FLAG_ONE_BIT;
    return o;
  endfunction

  // one line per mismatch, counted
  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_row(input logic [3:0] kind, input logic [15:0] w1,
                         input logic [15:0] w2, input logic [7:0] fl,
                         input logic known, input logic [15:0] res,
                         input logic [7:0] flg);
    table_row_t row;
    row.op.kind           = kind;
    row.op.first_operand  = w1;
    row.op.second_operand = w2;
    row.op.flags_in       = fl;
    row.known             = known;
    row.want.result       = res;
    row.want.flags_out    = flg;
    directed_table.push_back(row);
  endtask

  // present one operation after a random idle gap, hold until the transfer
  task automatic issue_op(input c80alu_pkg::alu_in_t op, input int idle_pct,
                          input logic known, input c80alu_pkg::alu_out_t want);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    req   <= op;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_alu_results.push_back(known ? want : alu_predict(op));
  endtask

  // hold off until every outstanding result is back
  task automatic wait_all_returned();
    start <= 1'b0;
    while (pending_alu_results.size() != 0) @(posedge clk);
  endtask

  // operand with a bias toward carry and nibble edges
  function automatic logic [15:0] pick_operand();
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(0, 9))
      0: w[7:0] = 8'h00;
      1: w[7:0] = 8'hFF;
      2: w[3:0] = 4'hF;
      3: w[3:0] = 4'h0;
      4: w = 16'hFFFF;
      5: w = 16'h0000;
      default: begin
      end
    endcase
    return w;
  endfunction

  task automatic random_phase(input int count, input int idle_pct);
    c80alu_pkg::alu_in_t  op;
    c80alu_pkg::alu_out_t none;
    none = '0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0)
        op.kind = 4'($urandom_range(KIND_RSV12, KIND_RSV15));
      else
        op.kind = 4'($urandom_range(c80alu_pkg::KIND_ADD, c80alu_pkg::KIND_DAD));
      op.first_operand  = pick_operand();
      op.second_operand = pick_operand();
      if ($urandom_range(0, 7) == 0) op.second_operand[7:0] = op.first_operand[7:0];
      op.flags_in = 8'($urandom);
      issue_op(op, idle_pct, 1'b0, none);
    end
  endtask

  // result checker: every done pulse is one transfer
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_alu_results.size() == 0) begin
        report_mismatch("unexpected result", rsp.result, 16'h0000);
      end else begin
        oldest_want = pending_alu_results.pop_front();
        if (rsp.result !== oldest_want.result)
          report_mismatch("result", rsp.result, oldest_want.result);
        if (rsp.flags_out !== oldest_want.flags_out)
          report_mismatch("flags_out", {8'h00, rsp.flags_out},
                          {8'h00, oldest_want.flags_out});
      end
    end
  end

  // main sequence
  initial begin
    rst   <= 1'b1;
    start <= 1'b0;
    req   <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // extremes and special cases; known values typed where obvious
    add_row(c80alu_pkg::KIND_ADD, 16'h0000, 16'h0000, 8'h00, 1'b1, 16'h0000, 8'h46);
    add_row(c80alu_pkg::KIND_ADD, 16'hABFF, 16'hCD01, 8'h00, 1'b1, 16'h0000, 8'h57);
    add_row(c80alu_pkg::KIND_ADC, 16'h00FF, 16'h0000, 8'h01, 1'b0, 16'h0000, 8'h00);
    add_row(c80alu_pkg::KIND_ADC, 16'hFF7F, 16'h0080, 8'hFE, 1'b0, 16'h0000, 8'h00);
    add_row(c80alu_pkg::KIND_SUB, 16'h0000, 16'h0001, 8'h00, 1'b1, 16'h00FF, 8'h87);
    add_row(c80alu_pkg::KIND_SBB, 16'h0000, 16'h0000, 8'h01, 1'b0, 16'h0000, 8'h00);
    add_row(c80alu_pkg::KIND_SBB, 16'h0010, 16'hFF01, 8'h00, 1'b0, 16'h0000, 8'h00);
    add_row(c80alu_pkg::KIND_CMP, 16'h1242, 16'h3442, 8'h00, 1'b0, 16'h0000, 8'h00);
    add_row(c80alu_pkg::KIND_CMP, 16'h0010, 16'h0020, 8'hFF, 1'b0, 16'h0000, 8'h00);
    add_row(c80alu_pkg::KIND_ANA, 16'h0008, 16'h0000, 8'h01, 1'b0, 16'h0000, 8'h00);
    add_row(c80alu_pkg::KIND_ANA, 16'h00F7, 16'h0008, 8'h00, 1'b0, 16'h0000, 8'h00);
    add_row(c80alu_pkg::KIND_XRA, 16'h005A, 16'h005A, 8'hFF, 1'b1, 16'h0000, 8'h46);
    add_row(c80alu_pkg::KIND_ORA, 16'h0000, 16'h0000, 8'hFF, 1'b0, 16'h0000, 8'h00);
    add_row(c80alu_pkg::KIND_ORA, 16'h0080, 16'h0001, 8'h00, 1'b0, 16'h0000, 8'h00);
    add_row(c80alu_pkg::KIND_INR, 16'h00FF, 16'h0000, 8'h00, 1'b0, 16'h0000, 8'h00);
    add_row(c80alu_pkg::KIND_INR, 16'hFF0F, 16'h0000, 8'h01, 1'b0, 16'h0000, 8'h00);
    add_row(c80alu_pkg::KIND_DCR, 16'h0000, 16'h0000, 8'h00, 1'b0, 16'h0000, 8'h00);
    add_row(c80alu_pkg::KIND_DCR, 16'h0010, 16'hFFFF, 8'h01, 1'b0, 16'h0000, 8'h00);
    add_row(c80alu_pkg::KIND_RRC, 16'h0001, 16'h0000, 8'h00, 1'b0, 16'h0000, 8'h00);
    add_row(c80alu_pkg::KIND_RRC, 16'hFFFE, 16'h0000, 8'hFF, 1'b0, 16'h0000, 8'h00);
    add_row(c80alu_pkg::KIND_DAD, 16'hFFFF, 16'h0001, 8'h00, 1'b1, 16'h0000, 8'h03);
    add_row(c80alu_pkg::KIND_DAD, 16'hFFFF, 16'hFFFF, 8'hD5, 1'b1, 16'hFFFE, 8'hD7);
    add_row(KIND_RSV12, 16'h1234, 16'h0000, 8'hFF, 1'b1, 16'h1234, 8'hD7);
    add_row(KIND_RSV13, 16'h8001, 16'h5555, 8'h00, 1'b0, 16'h0000, 8'h00);
    add_row(KIND_RSV14, 16'h0000, 16'hFFFF, 8'hAA, 1'b0, 16'h0000, 8'h00);
    add_row(KIND_RSV15, 16'hFFFF, 16'hFFFF, 8'h28, 1'b1, 16'hFFFF, 8'h02);

    foreach (directed_table[i])
      issue_op(directed_table[i].op, 25, directed_table[i].known,
               directed_table[i].want);
    wait_all_returned();

    // sender at a quarter idle, then a full drain, then mostly idle, then back to back
    random_phase(700, 25);
    wait_all_returned();
    random_phase(700, 78);
    random_phase(600, 0);

    wait_all_returned();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_alu_results.size() == 0) begin
      $display("PASS cpu8080_alu_flags_top");
    end else begin
      $display("FAIL cpu8080_alu_flags_top");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("FAIL cpu8080_alu_flags_top");
    $finish;
  end

endmodule
